>>> sv/assert_macros.svh
// assertion macros shared by the planner rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_PROP(label, !(cond), msg)

`endif

>>> sv/fjlp_pkg.sv
// types and constants of the full justify line planner
// used by every module of the block, no dependencies
package fjlp_pkg;

  localparam int unsigned WordW   = 10;
  localparam int unsigned CountW  = 9;
  localparam int unsigned WidthW  = 8;
  localparam int unsigned UsedW   = 10;
  localparam int unsigned LenSumW = 11;

  localparam logic [WidthW-1:0] LineWidthReset = 8'd100;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    CmdFull,
    CmdLast,
    CmdOver
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [CountW-1:0]   words;
    logic [WidthW-1:0]   chars;
    logic                fin;
  } line_cmd_t;

  typedef struct packed {
    logic      valid;
    line_cmd_t cmd;
  } cmd_push_t;

endpackage

>>> sv/fjlp_front.sv
// front end: takes word transactions, keeps the open line, issues line commands
// depends on fjlp_pkg and assert_macros.svh
`include "assert_macros.svh"

module fjlp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fjlp_pkg::WordW-1:0]      word_length_i,
  input  logic                            final_word_i,
  input  logic [fjlp_pkg::WidthW-1:0]     line_width_i,
  input  logic                            fifo_full_i,
  output fjlp_pkg::cmd_push_t             push_o
);

  logic                          hold_q, hold_d;
  logic [fjlp_pkg::WordW-1:0]    len_q, len_d;
  logic                          fin_q, fin_d;
  logic [fjlp_pkg::CountW-1:0]   words_q, words_d;
  logic [fjlp_pkg::WidthW-1:0]   chars_q, chars_d;

  logic                          over;
  logic [fjlp_pkg::LenSumW-1:0]  need;
  logic                          nofit;
  logic [fjlp_pkg::CountW-1:0]   new_words;
  logic [fjlp_pkg::WidthW-1:0]   new_chars;

  assign in_stall_o = hold_q;
  assign over       = len_q > {2'b00, line_width_i};
  // chars + gaps + one more space + new word
  assign need       = {3'b000, chars_q} + {2'b00, words_q} + {1'b0, len_q};
  assign nofit      = (words_q != '0) && (over || (need > {3'b000, line_width_i}));
  assign new_words  = words_q + 9'd1;
  assign new_chars  = chars_q + len_q[fjlp_pkg::WidthW-1:0];

  always_comb begin
    hold_d         = hold_q;
    len_d          = len_q;
    fin_d          = fin_q;
    words_d        = words_q;
    chars_d        = chars_q;
    push_o.valid   = 1'b0;
    push_o.cmd     = '0;
    if (hold_q) begin
      if (nofit) begin
        push_o.valid      = !fifo_full_i;
        push_o.cmd.kind   = fjlp_pkg::CmdFull;
        push_o.cmd.words  = words_q;
        push_o.cmd.chars  = chars_q;
        push_o.cmd.fin    = 1'b0;
        if (!fifo_full_i) begin
          words_d = '0;
          chars_d = '0;
        end
      end else if (over) begin
        push_o.valid      = !fifo_full_i;
        push_o.cmd.kind   = fjlp_pkg::CmdOver;
        push_o.cmd.words  = 9'd1;
        push_o.cmd.chars  = '0;
        push_o.cmd.fin    = fin_q;
        if (!fifo_full_i) begin
          hold_d = 1'b0;
        end
      end else if (fin_q) begin
        push_o.valid      = !fifo_full_i;
        push_o.cmd.kind   = fjlp_pkg::CmdLast;
        push_o.cmd.words  = new_words;
        push_o.cmd.chars  = new_chars;
        push_o.cmd.fin    = 1'b1;
        if (!fifo_full_i) begin
          words_d = '0;
          chars_d = '0;
          hold_d  = 1'b0;
        end
      end else begin
        words_d = new_words;
        chars_d = new_chars;
        hold_d  = 1'b0;
      end
    end else if (in_valid_i) begin
      hold_d = 1'b1;
      len_d  = word_length_i;
      fin_d  = final_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 1'b0;
      words_q <= '0;
      chars_q <= '0;
    end else begin
      hold_q  <= hold_d;
      words_q <= words_d;
      chars_q <= chars_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    fin_q <= fin_d;
  end

  `ASSERT_PROP(a_last_clears,
    push_o.valid && push_o.cmd.kind == fjlp_pkg::CmdLast |=> words_q == '0,
    "open line not cleared after final line")
  `ASSERT_NEVER(a_over_alone,
    push_o.valid && push_o.cmd.kind == fjlp_pkg::CmdOver && words_q != '0,
    "overlong word issued with open line")
  `ASSERT_NEVER(a_push_needs_hold, push_o.valid && !hold_q,
    "line command issued without a held word")

endmodule

>>> sv/fjlp_fifo.sv
// short command queue between front and back end
// depends on fjlp_pkg and assert_macros.svh
`include "assert_macros.svh"

module fjlp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fjlp_pkg::cmd_push_t   push_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output fjlp_pkg::line_cmd_t   head_o
);

  fjlp_pkg::line_cmd_t            mem_q [fjlp_pkg::FifoDepth];
  logic [fjlp_pkg::FifoAw-1:0]    wr_q, rd_q;
  logic [fjlp_pkg::FifoCw-1:0]    cnt_q, cnt_d;

  assign full_o  = cnt_q == fjlp_pkg::FifoCw'(fjlp_pkg::FifoDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i.valid, pop_i})
      2'b10:   cnt_d = cnt_q + fjlp_pkg::FifoCw'(1);
      2'b01:   cnt_d = cnt_q - fjlp_pkg::FifoCw'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.valid) begin
        wr_q <= wr_q + fjlp_pkg::FifoAw'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + fjlp_pkg::FifoAw'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.cmd;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i.valid && full_o, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "pop from empty queue")
  `ASSERT_NEVER(a_cnt_in_range, cnt_q > fjlp_pkg::FifoCw'(fjlp_pkg::FifoDepth),
    "queue count out of range")

endmodule

>>> sv/fjlp_back.sv
// back end: turns line commands into descriptors, serial divider for gap spread
// depends on fjlp_pkg and assert_macros.svh
`include "assert_macros.svh"

module fjlp_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [fjlp_pkg::WidthW-1:0]     line_width_i,
  input  logic                            fifo_empty_i,
  input  fjlp_pkg::line_cmd_t             head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fjlp_pkg::CountW-1:0]     words_in_line_o,
  output logic [fjlp_pkg::WidthW-1:0]     gap_spaces_o,
  output logic [fjlp_pkg::WidthW-1:0]     wide_gaps_o,
  output logic [fjlp_pkg::WidthW-1:0]     trailing_pad_o,
  output logic                            last_line_o,
  output logic                            overlong_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [2:0]                     cnt_q, cnt_d;
  logic [fjlp_pkg::WidthW:0]      rem_q, rem_d;
  logic [fjlp_pkg::WidthW-1:0]    quo_q, quo_d;
  logic [fjlp_pkg::WidthW-1:0]    div_q, div_d;
  logic [fjlp_pkg::CountW-1:0]    dwords_q, dwords_d;

  logic                           out_valid_q, out_valid_d;
  logic [fjlp_pkg::CountW-1:0]    words_q, words_d;
  logic [fjlp_pkg::WidthW-1:0]    gap_q, gap_d;
  logic [fjlp_pkg::WidthW-1:0]    wide_q, wide_d;
  logic [fjlp_pkg::WidthW-1:0]    pad_q, pad_d;
  logic                           last_q, last_d;
  logic                           over_q, over_d;

  logic                           out_free;
  logic                           spread;
  logic [fjlp_pkg::WidthW-1:0]    spare;
  logic [fjlp_pkg::UsedW-1:0]     used;
  logic [fjlp_pkg::UsedW-1:0]     last_rest;
  logic [fjlp_pkg::WidthW:0]      shifted;
  logic                           ge;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign spread    = head_i.kind == fjlp_pkg::CmdFull && head_i.words > 9'd1;
  assign spare     = (line_width_i >= head_i.chars) ? line_width_i - head_i.chars : '0;
  assign used      = {2'b00, head_i.chars} + {1'b0, head_i.words} - 10'd1;
  assign last_rest = {2'b00, line_width_i} - used;
  assign shifted   = {rem_q[fjlp_pkg::WidthW-1:0], quo_q[fjlp_pkg::WidthW-1]};
  assign ge        = shifted >= {1'b0, div_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_d       = div_q;
    dwords_d    = dwords_q;
    out_valid_d = out_valid_q && out_stall_i;
    words_d     = words_q;
    gap_d       = gap_q;
    wide_d      = wide_q;
    pad_d       = pad_q;
    last_d      = last_q;
    over_d      = over_q;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          if (spread) begin
            pop_o    = 1'b1;
            state_d  = ST_DIV;
            cnt_d    = '0;
            rem_d    = '0;
            quo_d    = spare;
            div_d    = head_i.words[fjlp_pkg::WidthW-1:0] - 8'd1;
            dwords_d = head_i.words;
          end else if (out_free) begin
            pop_o       = 1'b1;
            out_valid_d = 1'b1;
            words_d     = head_i.words;
            wide_d      = '0;
            last_d      = 1'b0;
            over_d      = 1'b0;
            case (head_i.kind)
              fjlp_pkg::CmdLast: begin
                gap_d  = (head_i.words > 9'd1) ? 8'd1 : 8'd0;
                pad_d  = ({2'b00, line_width_i} > used) ?
                         last_rest[fjlp_pkg::WidthW-1:0] : '0;
                last_d = 1'b1;
              end
              fjlp_pkg::CmdOver: begin
                gap_d  = '0;
                pad_d  = '0;
                last_d = head_i.fin;
                over_d = 1'b1;
              end
              default: begin
                gap_d = '0;
                pad_d = spare;
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        rem_d = ge ? shifted - {1'b0, div_q} : shifted;
        quo_d = {quo_q[fjlp_pkg::WidthW-2:0], ge};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          words_d     = dwords_q;
          gap_d       = quo_q;
          wide_d      = rem_q[fjlp_pkg::WidthW-1:0];
          pad_d       = '0;
          last_d      = 1'b0;
          over_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    div_q    <= div_d;
    dwords_q <= dwords_d;
    words_q  <= words_d;
    gap_q    <= gap_d;
    wide_q   <= wide_d;
    pad_q    <= pad_d;
    last_q   <= last_d;
    over_q   <= over_d;
  end

  assign out_valid_o     = out_valid_q;
  assign words_in_line_o = words_q;
  assign gap_spaces_o    = gap_q;
  assign wide_gaps_o     = wide_q;
  assign trailing_pad_o  = pad_q;
  assign last_line_o     = last_q;
  assign overlong_o      = over_q;

  `ASSERT_PROP(a_rem_below_div, state_q == ST_DIV && cnt_q == 3'd7 |=> rem_q < {1'b0, div_q}, "divider remainder not below divisor")
  `ASSERT_NEVER(a_pop_idle_only, pop_o && state_q != ST_IDLE, "queue popped while divider busy")
  `ASSERT_PROP(a_spread_keeps_out, state_q == ST_OUT && out_free |=> out_valid_q && !over_q && !last_q, "spread line descriptor not loaded")

endmodule

>>> sv/full_justify_line_planner_unit.sv
// full justify line planner: greedy packing of word lengths into justified lines
// top level, depends on fjlp_pkg, fjlp_front, fjlp_fifo and fjlp_back
//
// Input channel: one transaction per word (word_length_i, final_word_i), taken when
// in_valid_i is high and in_stall_o is low. Output channel: one transaction per
// finished line, held in an output register until out_stall_i is low.
// Configuration: cfg_we_i writes cfg_wdata_i to the line width. The user must do so
// only while idle; the block does not enforce this. A word transaction passes the
// front end as a capture, then up to two line commands into a four-entry queue.
// The back end issues a simple line (single word, final line, overlong word) straight
// from the queue head, and a spread line of several words once the bit-per-cycle
// divider of spare spaces by gaps has run; both are registered as the descriptor.
// Reset empties the open line and the queue, drops any held descriptor and sets
// the line width to 100. While the receiver stalls the descriptor stays put, the
// queue fills and the front end then stalls the sender.

module full_justify_line_planner_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fjlp_pkg::WidthW-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fjlp_pkg::WordW-1:0]      word_length_i,
  input  logic                            final_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fjlp_pkg::CountW-1:0]     words_in_line_o,
  output logic [fjlp_pkg::WidthW-1:0]     gap_spaces_o,
  output logic [fjlp_pkg::WidthW-1:0]     wide_gaps_o,
  output logic [fjlp_pkg::WidthW-1:0]     trailing_pad_o,
  output logic                            last_line_o,
  output logic                            overlong_o
);

  logic [fjlp_pkg::WidthW-1:0]  width_q;
  fjlp_pkg::cmd_push_t          push;
  fjlp_pkg::line_cmd_t          head;
  logic                         full;
  logic                         empty;
  logic                         pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= fjlp_pkg::LineWidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  fjlp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .word_length_i (word_length_i),
    .final_word_i  (final_word_i),
    .line_width_i  (width_q),
    .fifo_full_i   (full),
    .push_o        (push)
  );

  fjlp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  fjlp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .line_width_i    (width_q),
    .fifo_empty_i    (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .words_in_line_o (words_in_line_o),
    .gap_spaces_o    (gap_spaces_o),
    .wide_gaps_o     (wide_gaps_o),
    .trailing_pad_o  (trailing_pad_o),
    .last_line_o     (last_line_o),
    .overlong_o      (overlong_o)
  );

endmodule
